// ===== sv/swept_circle_collision_test_defines.svh =====
// Assertion macros shared by the swept circle collision test RTL.
`ifndef SWEPT_CIRCLE_COLLISION_TEST_DEFINES_SVH
`define SWEPT_CIRCLE_COLLISION_TEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Checks the cycle that follows an asserted reset.
`define SCS_ASSERT_RST(label, cons, msg) \
    label: assert property (@(posedge aclk) !aresetn |=> (cons)) else $error(msg);

`endif

// ===== sv/scs_pkg.sv =====
// Shared widths and pipeline sideband types for the swept circle collision test.
`timescale 1ns / 1ps
`default_nettype none

package scs_pkg;

    localparam int COORD_W    = 16;
    localparam int RAD_W      = 15;
    localparam int DIFF_W     = 17;
    localparam int RSUM_W     = 16;
    localparam int PROD_W     = 34;
    localparam int L2_W       = 34;
    localparam int DOT_W      = 35;
    localparam int MAG_W      = 33;
    localparam int RSQ_W      = 32;
    localparam int WIDE_W     = 66;
    localparam int ROOT_W     = 33;
    localparam int N_W        = 36;
    localparam int NUM_W      = 34;
    localparam int QUO_W      = 16;
    localparam int TIME_W     = 17;
    localparam int SQRT_DEPTH = ROOT_W;
    localparam int DIV_DEPTH  = QUO_W;
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 56;

    // Hit time of minus one frame in Q1.16.
    localparam logic [TIME_W-1:0] TIME_MINUS_ONE = 17'h10000;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [DIFF_W-1:0]  vx;
        logic signed [DIFF_W-1:0]  vy;
    } geom_t;

    typedef struct packed {
        geom_t                    geom;
        logic signed [DOT_W-1:0]  dot;
        logic [L2_W-1:0]          l2;
        logic                     ok;
    } sq_side_t;

    typedef struct packed {
        geom_t geom;
        logic  hit;
        logic  neg;
        logic  full;
    } dv_side_t;

endpackage

`default_nettype wire

// ===== sv/scs_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none

module scs_sqrt
    import scs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [WIDE_W-1:0] in_rad,
    input  wire sq_side_t          in_side,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output sq_side_t               out_side
);

    localparam int TW = WIDE_W + 1;

    logic [WIDE_W-1:0] rem_reg  [SQRT_DEPTH];
    logic [ROOT_W-1:0] root_reg [SQRT_DEPTH];
    sq_side_t          side_reg [SQRT_DEPTH];
    logic              vld_reg  [SQRT_DEPTH];

    genvar i;
    for (i = 0; i < SQRT_DEPTH; i++) begin : g_stage
        localparam int K = ROOT_W - 1 - i;

        logic [WIDE_W-1:0] rem_prev;
        logic [ROOT_W-1:0] root_prev;
        sq_side_t          side_prev;
        logic              vld_prev;
        logic [TW-1:0]     trial;
        logic              take;
        logic [WIDE_W-1:0] rem_next;
        logic [ROOT_W-1:0] root_next;

        if (i == 0) begin : g_first
            assign rem_prev  = in_rad;
            assign root_prev = '0;
            assign side_prev = in_side;
            assign vld_prev  = in_valid;
        end else begin : g_rest
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign side_prev = side_reg[i-1];
            assign vld_prev  = vld_reg[i-1];
        end

        // Setting bit K grows the square by (root << (K+1)) + 2^(2K).
        always_comb begin
            trial     = (TW'(root_prev) << (K + 1)) | (TW'(1) << (2 * K));
            take      = ({1'b0, rem_prev} >= trial);
            rem_next  = take ? WIDE_W'({1'b0, rem_prev} - trial) : rem_prev;
            root_next = take ? (root_prev | (ROOT_W'(1) << K)) : root_prev;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_DEPTH-1];
    assign out_root  = root_reg[SQRT_DEPTH-1];
    assign out_side  = side_reg[SQRT_DEPTH-1];

endmodule

`default_nettype wire

// ===== sv/scs_div.sv =====
// Pipelined restoring divider for a fraction below one, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module scs_div
    import scs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] in_num,
    input  wire logic [L2_W-1:0]  in_den,
    input  wire dv_side_t         in_side,
    output logic                  out_valid,
    output logic [QUO_W-1:0]      out_quo,
    output logic                  out_rem_nz,
    output dv_side_t              out_side
);

    logic [NUM_W-1:0] rem_reg  [DIV_DEPTH];
    logic [L2_W-1:0]  den_reg  [DIV_DEPTH];
    logic [QUO_W-1:0] quo_reg  [DIV_DEPTH];
    dv_side_t         side_reg [DIV_DEPTH];
    logic             vld_reg  [DIV_DEPTH];

    genvar i;
    for (i = 0; i < DIV_DEPTH; i++) begin : g_stage
        logic [NUM_W-1:0] rem_prev;
        logic [L2_W-1:0]  den_prev;
        logic [QUO_W-1:0] quo_prev;
        dv_side_t         side_prev;
        logic             vld_prev;
        logic [NUM_W:0]   rem2;
        logic             ge;
        logic [NUM_W-1:0] rem_next;

        if (i == 0) begin : g_first
            assign rem_prev  = in_num;
            assign den_prev  = in_den;
            assign quo_prev  = '0;
            assign side_prev = in_side;
            assign vld_prev  = in_valid;
        end else begin : g_rest
            assign rem_prev  = rem_reg[i-1];
            assign den_prev  = den_reg[i-1];
            assign quo_prev  = quo_reg[i-1];
            assign side_prev = side_reg[i-1];
            assign vld_prev  = vld_reg[i-1];
        end

        always_comb begin
            rem2     = {rem_prev, 1'b0};
            ge       = (rem2 >= {1'b0, den_prev});
            rem_next = ge ? NUM_W'(rem2 - {1'b0, den_prev}) : NUM_W'(rem2);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_prev;
                quo_reg[i]  <= {quo_prev[QUO_W-2:0], ge};
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid  = vld_reg[DIV_DEPTH-1];
    assign out_quo    = quo_reg[DIV_DEPTH-1];
    assign out_rem_nz = (rem_reg[DIV_DEPTH-1] != '0);
    assign out_side   = side_reg[DIV_DEPTH-1];

endmodule

`default_nettype wire

// ===== sv/swept_circle_collision_test.sv =====
// Swept circle against circle collision test, fully pipelined, top level.
//
// The s_ channel carries one circle pair per transfer; the m_ channel returns
// one result per pair, in order. m_tuser is the hit flag; on a miss the
// contact point and hit time are zero.
// From an input transfer to the matching result a pair passes seven front
// stages (differences, products, sums, wide products, compare), a 33-stage
// square root with one root bit per stage, one stage for the entry distance,
// a 16-stage divider with one time bit per stage, and three stages for the
// time, the contact offset products and the saturated output.
// Throughput is one pair per cycle; every stage is a register with a valid bit.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline stops and s_tready falls in the same cycle; nothing is dropped or
// repeated. Bubbles are carried as empty stages and cost no throughput.
// Reset clears all valid bits; no result is pending afterwards.
`timescale 1ns / 1ps
`default_nettype none
`include "swept_circle_collision_test_defines.svh"

module swept_circle_collision_test
    import scs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // a_x, a_y, a_dx, a_dy, a_rad, b_x, b_y, b_dx, b_dy, b_rad, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // contact_x, contact_y, hit_time, zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // hit
    output logic                       m_tuser
);

    logic adv;

    logic signed [COORD_W-1:0] a_x, a_y, a_dx, a_dy, b_x, b_y, b_dx, b_dy;
    logic [RAD_W-1:0]          a_rad, b_rad;

    assign a_x   = s_tdata[15:0];
    assign a_y   = s_tdata[31:16];
    assign a_dx  = s_tdata[47:32];
    assign a_dy  = s_tdata[63:48];
    assign a_rad = s_tdata[78:64];
    assign b_x   = s_tdata[94:79];
    assign b_y   = s_tdata[110:95];
    assign b_dx  = s_tdata[126:111];
    assign b_dy  = s_tdata[142:127];
    assign b_rad = s_tdata[157:143];

    // Stage registers.
    logic                     vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic                     vld6_reg, vld7_reg, vld8_reg, vld9_reg, vld10_reg;
    logic                     m_tvalid_reg;
    geom_t                    g1_reg, g2_reg, g3_reg, g4_reg, g5_reg, g6_reg;
    logic signed [DIFF_W-1:0] abx1_reg, aby1_reg;
    logic [RSUM_W-1:0]        r1_reg, r2_reg;
    logic signed [PROD_W-1:0] pvx2_reg, pvy2_reg, pdx2_reg, pdy2_reg, pcx2_reg, pcy2_reg;
    logic [L2_W-1:0]          l2_3_reg, l2_4_reg, l2_5_reg, l2_6_reg;
    logic signed [DOT_W-1:0]  dot3_reg, dot4_reg, dot5_reg, dot6_reg;
    logic signed [DOT_W-1:0]  cross3_reg;
    logic [RSQ_W-1:0]         rsq3_reg;
    logic                     ok4_reg, ok5_reg, ok6_reg;
    logic [MAG_W-1:0]         cm4_reg;
    logic [48:0]              prl4_reg, prh4_reg, cch5_reg;
    logic [49:0]              ccl5_reg;
    logic [WIDE_W-1:0]        rr5_reg, rr6_reg, cc6_reg, d7_reg;
    sq_side_t                 side7_reg;
    dv_side_t                 side8_reg;
    logic [NUM_W-1:0]         num8_reg;
    logic [L2_W-1:0]          den8_reg;
    geom_t                    g9_reg, g10_reg;
    logic                     hit9_reg, hit10_reg;
    logic signed [TIME_W-1:0] t9_reg, t10_reg;
    logic signed [PROD_W-1:0] px10_reg, py10_reg;
    logic                     hit_reg;
    logic [COORD_W-1:0]       cx_reg, cy_reg;
    logic [TIME_W-1:0]        t_reg;

    // Next values of the combinational stages.
    sq_side_t                 side7_next;
    logic [WIDE_W:0]          diff_next;
    logic signed [N_W-1:0]    n_next, l2s_next, nsum_next, nmag_next;
    dv_side_t                 side8_next;
    logic [TIME_W-1:0]        tmag_next;
    logic signed [TIME_W-1:0] t_next;
    logic signed [18:0]       sx_next, sy_next;

    logic                     sq_vld;
    logic [ROOT_W-1:0]        sq_root;
    sq_side_t                 sq_side;
    logic                     dv_vld;
    logic [QUO_W-1:0]         dv_quo;
    logic                     dv_rnz;
    dv_side_t                 dv_side;

    function automatic logic [COORD_W-1:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767) begin
            return 16'h7FFF;
        end else if (v < -19'sd32768) begin
            return 16'h8000;
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg     <= 1'b0;
            vld2_reg     <= 1'b0;
            vld3_reg     <= 1'b0;
            vld4_reg     <= 1'b0;
            vld5_reg     <= 1'b0;
            vld6_reg     <= 1'b0;
            vld7_reg     <= 1'b0;
            vld8_reg     <= 1'b0;
            vld9_reg     <= 1'b0;
            vld10_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg     <= s_tvalid;
            vld2_reg     <= vld1_reg;
            vld3_reg     <= vld2_reg;
            vld4_reg     <= vld3_reg;
            vld5_reg     <= vld4_reg;
            vld6_reg     <= vld5_reg;
            vld7_reg     <= vld6_reg;
            vld8_reg     <= sq_vld;
            vld9_reg     <= dv_vld;
            vld10_reg    <= vld9_reg;
            m_tvalid_reg <= vld10_reg;
        end
    end

    // Front end: relative motion, products, exact squared distances.
    always_ff @(posedge aclk) begin
        if (adv) begin
            g1_reg.ax <= a_x;
            g1_reg.ay <= a_y;
            g1_reg.vx <= DIFF_W'(a_dx) - DIFF_W'(b_dx);
            g1_reg.vy <= DIFF_W'(a_dy) - DIFF_W'(b_dy);
            abx1_reg  <= DIFF_W'(b_x) - DIFF_W'(a_x);
            aby1_reg  <= DIFF_W'(b_y) - DIFF_W'(a_y);
            r1_reg    <= RSUM_W'(a_rad) + RSUM_W'(b_rad);

            g2_reg   <= g1_reg;
            pvx2_reg <= g1_reg.vx * g1_reg.vx;
            pvy2_reg <= g1_reg.vy * g1_reg.vy;
            pdx2_reg <= abx1_reg * g1_reg.vx;
            pdy2_reg <= aby1_reg * g1_reg.vy;
            pcx2_reg <= abx1_reg * g1_reg.vy;
            pcy2_reg <= aby1_reg * g1_reg.vx;
            r2_reg   <= r1_reg;

            g3_reg     <= g2_reg;
            l2_3_reg   <= L2_W'($unsigned(pvx2_reg + pvy2_reg));
            dot3_reg   <= DOT_W'(pdx2_reg) + DOT_W'(pdy2_reg);
            cross3_reg <= DOT_W'(pcx2_reg) - DOT_W'(pcy2_reg);
            rsq3_reg   <= r2_reg * r2_reg;

            // The wide products are split at bit 17 and summed a stage later.
            g4_reg   <= g3_reg;
            l2_4_reg <= l2_3_reg;
            dot4_reg <= dot3_reg;
            ok4_reg  <= (l2_3_reg != '0) && !dot3_reg[DOT_W-1] && (dot3_reg != '0);
            cm4_reg  <= cross3_reg[DOT_W-1] ? MAG_W'(-cross3_reg) : MAG_W'(cross3_reg);
            prl4_reg <= rsq3_reg * l2_3_reg[16:0];
            prh4_reg <= rsq3_reg * l2_3_reg[33:17];

            g5_reg   <= g4_reg;
            l2_5_reg <= l2_4_reg;
            dot5_reg <= dot4_reg;
            ok5_reg  <= ok4_reg;
            rr5_reg  <= {17'b0, prl4_reg} + {prh4_reg, 17'b0};
            ccl5_reg <= cm4_reg * cm4_reg[16:0];
            cch5_reg <= cm4_reg * cm4_reg[32:17];

            g6_reg   <= g5_reg;
            l2_6_reg <= l2_5_reg;
            dot6_reg <= dot5_reg;
            ok6_reg  <= ok5_reg;
            rr6_reg  <= rr5_reg;
            cc6_reg  <= {16'b0, ccl5_reg} + {cch5_reg, 17'b0};

            d7_reg    <= diff_next[WIDE_W-1:0];
            side7_reg <= side7_next;
        end
    end

    // The line of motion must pass strictly within the radius sum.
    always_comb begin
        diff_next       = {1'b0, rr6_reg} - {1'b0, cc6_reg};
        side7_next.geom = g6_reg;
        side7_next.dot  = dot6_reg;
        side7_next.l2   = l2_6_reg;
        side7_next.ok   = ok6_reg && !diff_next[WIDE_W] && (diff_next[WIDE_W-1:0] != '0);
    end

    scs_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vld7_reg),
        .in_rad    (d7_reg),
        .in_side   (side7_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // n is the hit fraction scaled by the squared relative move.
    always_comb begin
        n_next          = N_W'(sq_side.dot) - $signed({3'b0, sq_root});
        l2s_next        = $signed({2'b0, sq_side.l2});
        nsum_next       = n_next + l2s_next;
        nmag_next       = n_next[N_W-1] ? -n_next : n_next;
        side8_next.geom = sq_side.geom;
        side8_next.hit  = sq_side.ok && (n_next < l2s_next);
        side8_next.neg  = n_next[N_W-1];
        side8_next.full = nsum_next[N_W-1] || (nsum_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side8_reg <= side8_next;
            num8_reg  <= NUM_W'(nmag_next);
            den8_reg  <= sq_side.l2;
        end
    end

    scs_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (vld8_reg),
        .in_num     (num8_reg),
        .in_den     (den8_reg),
        .in_side    (side8_reg),
        .out_valid  (dv_vld),
        .out_quo    (dv_quo),
        .out_rem_nz (dv_rnz),
        .out_side   (dv_side)
    );

    // Negative times round toward minus infinity, so a remainder adds one.
    always_comb begin
        tmag_next = {1'b0, dv_quo} + {{(TIME_W-1){1'b0}}, dv_rnz && dv_side.neg};
        if (dv_side.full) begin
            t_next = TIME_MINUS_ONE;
        end else if (dv_side.neg) begin
            t_next = -tmag_next;
        end else begin
            t_next = tmag_next;
        end
    end

    always_comb begin
        sx_next = 19'(g10_reg.ax) + 19'($signed(px10_reg[33:16]));
        sy_next = 19'(g10_reg.ay) + 19'($signed(py10_reg[33:16]));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g9_reg   <= dv_side.geom;
            hit9_reg <= dv_side.hit;
            t9_reg   <= t_next;

            g10_reg   <= g9_reg;
            hit10_reg <= hit9_reg;
            t10_reg   <= t9_reg;
            px10_reg  <= g9_reg.vx * t9_reg;
            py10_reg  <= g9_reg.vy * t9_reg;

            hit_reg <= hit10_reg;
            cx_reg  <= hit10_reg ? sat16(sx_next) : '0;
            cy_reg  <= hit10_reg ? sat16(sy_next) : '0;
            t_reg   <= hit10_reg ? t10_reg : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {7'b0, t_reg, cy_reg, cx_reg};

    `SCS_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "miss carries data")
    `SCS_ASSERT_NXT(a_stall_hold, !s_tready, $stable(vld9_reg) && $stable(vld10_reg), "stall moved pipeline")
    `SCS_ASSERT_RST(a_reset_empty, !m_tvalid, "result pending after reset")

endmodule

`default_nettype wire

// ===== verif/tb_swept_circle_collision_test.sv =====
// Self-checking testbench for the swept circle against circle collision test.
`timescale 1ns / 1ps

module tb_swept_circle_collision_test
    import scs_pkg::*;
();

    typedef struct {
        logic        hit;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [16:0] tm;
    } contact_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    contact_t contacts_due[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       errors = 0;
    longint   cycles = 0;

    always #1 aclk = ~aclk;

    swept_circle_collision_test dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic longint floor_div16(longint p);
        return p >>> 16;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // 128-bit arithmetic covers the discriminant products exactly.
    function automatic contact_t predict_contact(logic [159:0] d);
        contact_t res;
        longint ax, ay, bx, by, vx, vy, abx, aby, l2, dot, crs, n, t, rsum;
        logic signed [127:0] disc, root, trial;
        ax = $signed(d[15:0]);
        ay = $signed(d[31:16]);
        vx = longint'($signed(d[47:32])) - longint'($signed(d[126:111]));
        vy = longint'($signed(d[63:48])) - longint'($signed(d[142:127]));
        bx = $signed(d[94:79]);
        by = $signed(d[110:95]);
        rsum = longint'(d[78:64]) + longint'(d[157:143]);
        abx = bx - ax;
        aby = by - ay;
        l2 = vx * vx + vy * vy;
        dot = abx * vx + aby * vy;
        crs = abx * vy - aby * vx;
        res = '{1'b0, 16'd0, 16'd0, 17'd0};
        if (l2 == 0 || dot <= 0) return res;
        disc = 128'(rsum) * rsum * l2 - 128'(crs) * crs;
        if (disc <= 0) return res;
        root = 0;
        for (int b = 40; b >= 0; b--) begin
            trial = root | (128'sd1 << b);
            if (trial * trial <= disc) root = trial;
        end
        n = dot - longint'(root);
        if (n >= l2) return res;
        if (n <= -l2) t = -65536;
        else if (n >= 0) t = (n * 65536) / l2;
        else t = -(((-n) * 65536 + l2 - 1) / l2);
        res.hit = 1'b1;
        res.cx = 16'(clamp16(ax + floor_div16(vx * t)));
        res.cy = 16'(clamp16(ay + floor_div16(vy * t)));
        res.tm = 17'(t);
        return res;
    endfunction

    function automatic logic [159:0] pack_pair(logic [15:0] ax, ay, adx, ady,
            logic [14:0] ar, logic [15:0] bx, by, bdx, bdy, logic [14:0] br);
        return {2'd0, br, bdy, bdx, by, bx, ar, ady, adx, ay, ax};
    endfunction

    task automatic send_pair(logic [159:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        contacts_due.push_back(predict_contact(d));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Receiver stall pattern and result check, on the same edge.
    always @(posedge aclk) begin
        contact_t exp_c;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (contacts_due.size() == 0) begin
                $error("result transfer with no pair outstanding");
                errors++;
            end else begin
                exp_c = contacts_due.pop_front();
                if (m_tuser !== exp_c.hit) begin
                    $error("hit expected %0d actual %0d", exp_c.hit, m_tuser); errors++;
                end
                if (m_tdata[15:0] !== exp_c.cx) begin
                    $error("contact_x expected %0d actual %0d", $signed(exp_c.cx),
                           $signed(m_tdata[15:0])); errors++;
                end
                if (m_tdata[31:16] !== exp_c.cy) begin
                    $error("contact_y expected %0d actual %0d", $signed(exp_c.cy),
                           $signed(m_tdata[31:16])); errors++;
                end
                if (m_tdata[48:32] !== exp_c.tm) begin
                    $error("hit_time expected %0d actual %0d", $signed(exp_c.tm),
                           $signed(m_tdata[48:32])); errors++;
                end
                if (m_tdata[55:49] !== '0) begin
                    $error("pad expected 0 actual %0h", m_tdata[55:49]); errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycles > 4000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed(16'($urandom_range(4000))) - 2000);
            2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed(16'($urandom_range(400))) - 200);
        endcase
    endfunction

    task automatic test_extremes();
        logic [15:0] mx = 16'h7fff, mn = 16'h8000, z = 16'd0;
        logic [14:0] rm = 15'h7fff, r0 = 15'd0, r1 = 15'd1, r10 = 15'd10, r50 = 15'd50;
        logic [15:0] c10 = 16'd10, c20 = 16'd20, c30 = 16'd30, c50 = 16'd50;
        logic [15:0] c100 = 16'd100, c256 = 16'd256, n256 = 16'hff00;
        send_pair(pack_pair(z, z, z, z, r10, c100, z, z, z, r10));          // no relative motion
        send_pair(pack_pair(z, z, c256, z, r10, c100, z, z, z, r10));       // hit head on
        send_pair(pack_pair(z, z, n256, z, r10, c100, z, z, z, r10));       // moving apart
        send_pair(pack_pair(z, z, z, c256, r10, c100, z, z, z, r10));       // sideways
        send_pair(pack_pair(z, z, c256, z, r10, c100, c20, z, z, r10));     // tangent touch
        send_pair(pack_pair(z, z, c256, z, r0, c100, z, z, z, r0));         // zero radii
        send_pair(pack_pair(z, z, c10, z, r50, c30, z, z, z, r50));         // overlapping
        send_pair(pack_pair(z, z, c50, z, r10, c100, z, z, z, r10));        // falls short
        send_pair(pack_pair(mn, mn, mx, mx, rm, mx, mx, mn, mn, rm));
        send_pair(pack_pair(mx, mx, mn, mn, rm, mn, mn, mx, mx, rm));
        send_pair(pack_pair(mn, mx, mx, mn, r0, mx, mn, mn, mx, rm));
        send_pair(pack_pair(mx, mn, mn, mx, rm, mn, mx, mx, mn, r0));
        send_pair(pack_pair(mn, z, mx, z, r1, mx, z, mn, z, r1));
        send_pair(pack_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff, rm,
                            16'hffff, 16'hffff, 16'hffff, 16'h0000, rm));
    endtask

    task automatic test_random(int count);
        logic [15:0] ax, ay, bx, by, adx, ady, bdx, bdy;
        logic [14:0] ar, br;
        repeat (count) begin
            ax = pick_coord(); ay = pick_coord();
            adx = pick_coord(); ady = pick_coord();
            bdx = pick_coord(); bdy = pick_coord();
            ar = 15'($urandom); br = 15'($urandom);
            if ($urandom_range(99) < 70) begin
                // Place B ahead along A's relative move so hits are common.
                bx = 16'(ax + ($signed(adx - bdx) >>> $urandom_range(3)) +
                         $signed(16'($urandom_range(200))) - 100);
                by = 16'(ay + ($signed(ady - bdy) >>> $urandom_range(3)) +
                         $signed(16'($urandom_range(200))) - 100);
                ar = 15'($urandom_range(3000)); br = 15'($urandom_range(3000));
            end else begin
                bx = pick_coord(); by = pick_coord();
            end
            send_pair(pack_pair(ax, ay, adx, ady, ar, bx, by, bdx, bdy, br));
        end
    endtask

    task automatic set_idling(int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        set_idling(0, 0);   test_random(330);
        set_idling(62, 0);  test_random(320);
        set_idling(0, 62);  test_random(320);
        set_idling(21, 21); test_random(320);
        s_tvalid <= 1'b0;
        set_idling(0, 0);
        while (contacts_due.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
